// ===== hdl/twcc_pkg.sv =====
// Package for the two-way cache controller: request and result types, codes.
// No dependencies; used by the controller, its checker and the testbench by scoped names.
`default_nettype none

package twcc_pkg;

    // Request kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Policy register codes
    localparam logic MODE_WRITE_THROUGH = 1'b0;
    localparam logic MODE_WRITE_BACK    = 1'b1;

    // Largest value the traffic field can show
    localparam logic [5:0] TRAFFIC_MAX = 6'd63;

    typedef struct packed {
        logic        req_type;
        logic [31:0] byte_addr;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic        way_used;
        logic        filled;
        logic        wrote_back;
        logic [31:0] victim_addr;
        logic        memory_byte_write;
        logic [5:0]  traffic_bytes;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/twcc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module twcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/two_way_cache_controller_unit.sv =====
// Two-way set-associative cache tag and policy controller (LRU replacement).
// A request is held in the lookup stage registers, then its result in the output register.
// Throughput: one request per cycle while the result channel is not stalled; a set read in the tag RAM is forwarded
// from the previous request's write-back when both touch the same set.
// Reset: synchronous; afterwards a clearing pass zeroes every set of the tag RAM,
// during which requests are stalled (the policy register still writes).
// Depends on twcc_pkg and twcc_ram. BLOCK_BYTES and NUM_SETS are powers of two.
`default_nettype none

module two_way_cache_controller_unit #(
    parameter int BLOCK_BYTES = 16,
    parameter int NUM_SETS    = 64,
    parameter int ADDR_BITS   = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Policy register
    input  wire logic          i_cfg_wr_en,
    input  wire logic          i_cfg_wr_data,
    // Request channel
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire twcc_pkg::t_req i_in_req,
    // Result channel
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output twcc_pkg::t_res     o_out_res
);

    localparam int OFFS_W  = $clog2(BLOCK_BYTES);
    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int TAG_RAW = ADDR_BITS - OFFS_W - SET_W;
    localparam int TAG_W   = (TAG_RAW < 1) ? 1 : TAG_RAW;
    localparam int WAY_W   = 2 + TAG_W;
    localparam int ENT_W   = 1 + 2 * WAY_W;
    localparam logic [32:0] MASK33    = (33'd1 << ADDR_BITS) - 33'd1;
    localparam logic [31:0] ADDR_MASK = MASK33[31:0];
    localparam logic [9:0]  BLK_BYTES = 10'(BLOCK_BYTES);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    // Policy register
    logic r_write_back_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_back_mode <= twcc_pkg::MODE_WRITE_BACK;
        end else if (i_cfg_wr_en) begin
            r_write_back_mode <= i_cfg_wr_data;
        end
    end

    // Clearing pass after reset
    logic             r_clearing, n_clearing;
    logic [SET_W-1:0] r_clr_idx, n_clr_idx;
    always_comb begin
        n_clearing = r_clearing;
        n_clr_idx  = r_clr_idx;
        if (r_clearing) begin
            n_clr_idx = r_clr_idx + SET_W'(1);
            if (r_clr_idx == LAST_SET) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_idx  <= n_clr_idx;
        end
    end

    // Request decode
    logic [31:0]      in_addr;
    logic [31:0]      in_tag_full;
    logic [SET_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;
    assign in_addr     = i_in_req.byte_addr & ADDR_MASK;
    assign in_tag_full = in_addr >> (OFFS_W + SET_W);
    assign in_set      = in_addr[OFFS_W +: SET_W];
    assign in_tag      = in_tag_full[TAG_W-1:0];

    // Handshake
    logic accept, advance;
    logic r_s1_valid;
    logic r_out_valid;
    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_valid && !advance);
    assign accept     = i_in_valid && !o_in_stall;

    // Lookup stage registers
    logic             r_s1_write;
    logic [SET_W-1:0] r_s1_set;
    logic [TAG_W-1:0] r_s1_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_write <= i_in_req.req_type;
            r_s1_set   <= in_set;
            r_s1_tag   <= in_tag;
        end
    end

    // Tag RAM: one entry per set holding both ways and the recent-way bit
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata, new_entry;
    assign ram_we    = r_clearing || advance;
    assign ram_waddr = r_clearing ? r_clr_idx : r_s1_set;
    assign ram_wdata = r_clearing ? '0 : new_entry;

    twcc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // Forward the last written entry over the RAM's stale read
    logic             r_fwd_valid;
    logic [SET_W-1:0] r_fwd_set;
    logic [ENT_W-1:0] r_fwd_entry;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (advance) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fwd_set   <= r_s1_set;
            r_fwd_entry <= new_entry;
        end
    end

    logic [ENT_W-1:0] cur_entry;
    assign cur_entry = (r_fwd_valid && r_fwd_set == r_s1_set) ? r_fwd_entry : ram_rdata;

    // Lookup, policy and entry update
    logic             e_valid [2];
    logic             e_dirty [2];
    logic [TAG_W-1:0] e_tag   [2];
    logic             n_valid [2];
    logic             n_dirty [2];
    logic [TAG_W-1:0] n_tag   [2];
    logic             e_recent, n_recent;
    logic             hit0, hit1, victim;
    logic [9:0]       traffic;
    logic [63:0]      vblk_wide;
    twcc_pkg::t_res   res;

    always_comb begin
        for (int w = 0; w < 2; w++) begin
            e_valid[w] = cur_entry[1 + w * WAY_W];
            e_dirty[w] = cur_entry[2 + w * WAY_W];
            e_tag[w]   = cur_entry[3 + w * WAY_W +: TAG_W];
            n_valid[w] = e_valid[w];
            n_dirty[w] = e_dirty[w];
            n_tag[w]   = e_tag[w];
        end
        e_recent = cur_entry[0];
        n_recent = e_recent;

        hit0   = e_valid[0] && (e_tag[0] == r_s1_tag);
        hit1   = e_valid[1] && (e_tag[1] == r_s1_tag);
        victim = !e_valid[0] ? 1'b0 : (!e_valid[1] ? 1'b1 : !e_recent);

        vblk_wide = (64'(e_tag[victim]) << (SET_W + OFFS_W))
                  | (64'(r_s1_set) << OFFS_W);

        res     = '0;
        traffic = '0;
        if (hit0 || hit1) begin
            res.hit      = 1'b1;
            res.way_used = !hit0;
            n_recent     = !hit0;
            if (r_s1_write == twcc_pkg::REQ_WRITE) begin
                if (r_write_back_mode == twcc_pkg::MODE_WRITE_BACK) begin
                    n_dirty[!hit0] = 1'b1;
                end else begin
                    res.memory_byte_write = 1'b1;
                    traffic               = 10'd1;
                end
            end
        end else if (r_s1_write == twcc_pkg::REQ_WRITE
                     && r_write_back_mode == twcc_pkg::MODE_WRITE_THROUGH) begin
            // Write miss without allocation: byte goes straight to memory
            res.memory_byte_write = 1'b1;
            traffic               = 10'd1;
        end else begin
            // Allocate: write back a dirty victim, then fetch the block
            if (e_valid[victim] && e_dirty[victim]) begin
                res.wrote_back  = 1'b1;
                res.victim_addr = vblk_wide[31:0] & ADDR_MASK;
                traffic         = BLK_BYTES;
            end
            traffic         = traffic + BLK_BYTES;
            res.filled      = 1'b1;
            res.way_used    = victim;
            n_valid[victim] = 1'b1;
            n_tag[victim]   = r_s1_tag;
            n_dirty[victim] = (r_s1_write == twcc_pkg::REQ_WRITE);
            n_recent        = victim;
        end

        // Saturate to the field
        res.traffic_bytes = (traffic > 10'(twcc_pkg::TRAFFIC_MAX))
                          ? twcc_pkg::TRAFFIC_MAX : traffic[5:0];

        new_entry    = '0;
        new_entry[0] = n_recent;
        for (int w = 0; w < 2; w++) begin
            new_entry[1 + w * WAY_W]          = n_valid[w];
            new_entry[2 + w * WAY_W]          = n_dirty[w];
            new_entry[3 + w * WAY_W +: TAG_W] = n_tag[w];
        end
    end

    // Output register
    twcc_pkg::t_res r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

`default_nettype wire

// ===== hdl/twcc_checker.sv =====
// Port-level checker for the two-way cache controller, bound to its top level.
// Depends on twcc_pkg and two_way_cache_controller_unit.
`default_nettype none

module twcc_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire twcc_pkg::t_res o_out_res
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_res))
        else $error("result changed while stalled");

    // Hit and fill exclude each other; a write-back only comes with a fill
    a_hit_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_res.hit && o_out_res.filled)
                        && (!o_out_res.wrote_back || o_out_res.filled))
        else $error("inconsistent hit, fill and write-back flags");

    // Victim address only reported with a write-back
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.wrote_back |-> o_out_res.victim_addr == 32'd0)
        else $error("victim address without write-back");

    // A byte write to memory moves exactly one byte and never with a fill
    a_byte_traffic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.memory_byte_write
            |-> o_out_res.traffic_bytes == 6'd1 && !o_out_res.filled)
        else $error("byte write with wrong traffic");

endmodule

bind two_way_cache_controller_unit twcc_checker u_twcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for two_way_cache_controller_unit: directed and random requests, with
// results checked against a tag/LRU predictor kept in step with the controller.
// Depends on twcc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int BLK_BYTES   = 16;
    localparam int SET_COUNT   = 64;
    localparam int OFFSET_W    = 4;
    localparam int SET_W       = 6;
    localparam int TAG_W       = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int CHUNK_REQS  = 130;

    logic i_clk         = 1'b0;
    logic i_rst_n       = 1'b0;
    logic i_cfg_wr_en   = 1'b0;
    logic i_cfg_wr_data = 1'b0;
    logic i_in_valid    = 1'b0;
    logic i_out_stall   = 1'b0;
    twcc_pkg::t_req i_in_req = '0;
    logic o_in_stall;
    logic o_out_valid;
    twcc_pkg::t_res o_out_res;

    two_way_cache_controller_unit #(
        .BLOCK_BYTES(BLK_BYTES),
        .NUM_SETS(SET_COUNT),
        .ADDR_BITS(32)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_req(i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res(o_out_res)
    );

    // Predicted tag store
    logic             line_ok     [SET_COUNT][2];
    logic             line_modified [SET_COUNT][2];
    logic [TAG_W-1:0] line_tag_q  [SET_COUNT][2];
    logic             mru_way     [SET_COUNT];
    logic             policy_mode = twcc_pkg::MODE_WRITE_BACK;

    twcc_pkg::t_req queued_reqs[$];
    twcc_pkg::t_res expected_lookups[$];

    int unsigned sender_idle_pct  = 0;
    int unsigned result_stall_pct = 0;
    int unsigned error_count      = 0;
    int unsigned cycle_count      = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] make_addr(input logic [TAG_W-1:0] tag,
                                              input logic [SET_W-1:0] set_idx,
                                              input logic [OFFSET_W-1:0] offset);
        return {tag, set_idx, offset};
    endfunction

    // Lookup, replacement and policy for one request; updates the tag store
    function automatic twcc_pkg::t_res predict_lookup(input twcc_pkg::t_req req);
        twcc_pkg::t_res   res;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic             victim;
        int unsigned      traffic;
        res     = '0;
        traffic = 0;
        set_idx = req.byte_addr[OFFSET_W +: SET_W];
        tag     = req.byte_addr[31 -: TAG_W];

        if (line_ok[set_idx][0] && line_tag_q[set_idx][0] == tag) begin
            res.hit      = 1'b1;
            res.way_used = 1'b0;
        end else if (line_ok[set_idx][1] && line_tag_q[set_idx][1] == tag) begin
            res.hit      = 1'b1;
            res.way_used = 1'b1;
        end

        if (res.hit) begin
            mru_way[set_idx] = res.way_used;
            if (req.req_type == twcc_pkg::REQ_WRITE) begin
                if (policy_mode == twcc_pkg::MODE_WRITE_BACK) begin
                    line_modified[set_idx][res.way_used] = 1'b1;
                end else begin
                    res.memory_byte_write = 1'b1;
                    traffic = 1;
                end
            end
        end else if (req.req_type == twcc_pkg::REQ_WRITE
                     && policy_mode == twcc_pkg::MODE_WRITE_THROUGH) begin
            // no allocate: the byte goes straight to memory, LRU untouched
            res.memory_byte_write = 1'b1;
            traffic = 1;
        end else begin
            if (!line_ok[set_idx][0])
                victim = 1'b0;
            else if (!line_ok[set_idx][1])
                victim = 1'b1;
            else
                victim = ~mru_way[set_idx];
            // dirty victim goes back to memory in either mode
            if (line_ok[set_idx][victim] && line_modified[set_idx][victim]) begin
                res.wrote_back  = 1'b1;
                res.victim_addr = {line_tag_q[set_idx][victim], set_idx, {OFFSET_W{1'b0}}};
                traffic += BLK_BYTES;
            end
            traffic += BLK_BYTES;
            res.filled   = 1'b1;
            res.way_used = victim;
            line_ok[set_idx][victim]       = 1'b1;
            line_tag_q[set_idx][victim]    = tag;
            line_modified[set_idx][victim] = (req.req_type == twcc_pkg::REQ_WRITE);
            mru_way[set_idx]               = victim;
        end

        res.traffic_bytes = (traffic > twcc_pkg::TRAFFIC_MAX)
                          ? twcc_pkg::TRAFFIC_MAX : traffic[5:0];
        return res;
    endfunction

    task automatic check_result(input twcc_pkg::t_res got);
        twcc_pkg::t_res want;
        logic bad;
        if (expected_lookups.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("%0t: result with no request outstanding: %h", $realtime, got);
        end else begin
            want = expected_lookups.pop_front();
            bad = (got.hit !== want.hit) || (got.way_used !== want.way_used) ||
                  (got.filled !== want.filled) || (got.wrote_back !== want.wrote_back) ||
                  (got.victim_addr !== want.victim_addr) ||
                  (got.memory_byte_write !== want.memory_byte_write) ||
                  (got.traffic_bytes !== want.traffic_bytes);
            if (bad) begin
                error_count++;
                if (error_count <= REPORT_MAX) begin
                    $display("%0t: exp hit=%b way=%b fill=%b wb=%b va=%h mbw=%b tb=%0d",
                             $realtime, want.hit, want.way_used, want.filled,
                             want.wrote_back, want.victim_addr, want.memory_byte_write,
                             want.traffic_bytes);
                    $display("%0t: got hit=%b way=%b fill=%b wb=%b va=%h mbw=%b tb=%0d",
                             $realtime, got.hit, got.way_used, got.filled,
                             got.wrote_back, got.victim_addr, got.memory_byte_write,
                             got.traffic_bytes);
                end
            end
        end
    endtask

    // Request driver: predicts on acceptance, then offers the next queued request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                expected_lookups.push_back(predict_lookup(i_in_req));
            if (!i_in_valid || !o_in_stall) begin
                if (queued_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_req   <= queued_reqs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result(o_out_res);
        i_out_stall <= ($urandom_range(99) < result_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("two_way_cache_controller_unit verification failed");
            $finish;
        end
    end

    task automatic push_req(input logic kind, input logic [31:0] addr);
        twcc_pkg::t_req req;
        req.req_type  = kind;
        req.byte_addr = addr;
        queued_reqs.push_back(req);
    endtask

    // Returns once nothing is queued, offered or outstanding
    task automatic wait_until_idle();
        do
            @(negedge i_clk);
        while (queued_reqs.size() != 0 || i_in_valid || expected_lookups.size() != 0);
    endtask

    task automatic set_policy(input logic mode);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        policy_mode = mode;
        @(negedge i_clk);
    endtask

    // Mostly a few tags over a few sets so that hits, evictions and
    // back-to-back same-set requests are common; some fully random noise
    task automatic queue_random_chunk(input int unsigned count);
        logic [TAG_W-1:0] tag_pool [3];
        logic [SET_W-1:0] set_pool [4];
        logic [31:0]      addr;
        for (int i = 0; i < 3; i++) tag_pool[i] = TAG_W'($urandom);
        for (int i = 0; i < 4; i++) set_pool[i] = SET_W'($urandom_range(SET_COUNT - 1));
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(99) < 8)
                addr = $urandom;
            else
                addr = make_addr(tag_pool[$urandom_range(2)], set_pool[$urandom_range(3)],
                                 OFFSET_W'($urandom_range(BLK_BYTES - 1)));
            push_req($urandom_range(1) ? twcc_pkg::REQ_WRITE : twcc_pkg::REQ_READ, addr);
        end
    endtask

    initial begin : stimulus
        for (int s = 0; s < SET_COUNT; s++) begin
            mru_way[s] = 1'b0;
            for (int w = 0; w < 2; w++) begin
                line_ok[s][w]       = 1'b0;
                line_modified[s][w] = 1'b0;
                line_tag_q[s][w]    = '0;
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct  = 11;
        result_stall_pct = 60;

        // Write-back: fills, hits, LRU victims, dirty write-backs, address extremes
        set_policy(twcc_pkg::MODE_WRITE_BACK);
        push_req(twcc_pkg::REQ_READ,  32'h0000_0000);                     // tag zero, invalid
        push_req(twcc_pkg::REQ_READ,  32'h0000_000F);                     // hit way 0
        push_req(twcc_pkg::REQ_WRITE, make_addr(22'h3FFFFF, 6'd0, 4'd0)); // way 1 dirty
        push_req(twcc_pkg::REQ_WRITE, 32'hFFFF_FFFF);                     // top of space
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd1, 6'd0, 4'd3));      // clean victim
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd2, 6'd0, 4'd8));      // dirty victim
        push_req(twcc_pkg::REQ_WRITE, make_addr(22'd2, 6'd0, 4'd1));      // write hit way 1
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd1, 6'd0, 4'd0));      // read hit way 0
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd5, 6'd0, 4'd0));      // evicts way 1
        push_req(twcc_pkg::REQ_READ,  32'hFFFF_FFF0);                     // hit set 63
        push_req(twcc_pkg::REQ_WRITE, make_addr(22'h155555, 6'd63, 4'd7));
        push_req(twcc_pkg::REQ_WRITE, make_addr(22'h2AAAAA, 6'd63, 4'd0)); // all-ones victim
        wait_until_idle();

        // Write-through with dirty lines left from write-back mode
        set_policy(twcc_pkg::MODE_WRITE_THROUGH);
        push_req(twcc_pkg::REQ_WRITE, make_addr(22'h2AAAAA, 6'd63, 4'd0)); // hit, dirty kept
        push_req(twcc_pkg::REQ_WRITE, make_addr(22'd7, 6'd63, 4'd2));      // miss, no alloc
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd7, 6'd63, 4'd2));      // dirty victim
        push_req(twcc_pkg::REQ_READ,  make_addr(22'h2AAAAA, 6'd63, 4'd9));
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd9, 6'd63, 4'd0));
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd9, 6'd63, 4'd15));
        push_req(twcc_pkg::REQ_READ,  make_addr(22'd3, 6'd1, 4'd0));
        push_req(twcc_pkg::REQ_WRITE, make_addr(22'd3, 6'd1, 4'd4));
        push_req(twcc_pkg::REQ_READ,  32'h8000_0200);

        // Random traffic under three idle settings, policy switched per chunk
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct  = 11;
                    result_stall_pct = 60;
                end
                1: begin
                    sender_idle_pct  = 60;
                    result_stall_pct = 11;
                end
                default: begin
                    sender_idle_pct  = 0;
                    result_stall_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 4; chunk++) begin
                wait_until_idle();
                set_policy(((chunk + phase) % 2 == 0) ? twcc_pkg::MODE_WRITE_BACK
                                                      : twcc_pkg::MODE_WRITE_THROUGH);
                queue_random_chunk(CHUNK_REQS);
            end
        end

        wait_until_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("two_way_cache_controller_unit verification clean");
        else
            $display("two_way_cache_controller_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/twcc_pkg.sv
hdl/twcc_ram.sv
hdl/two_way_cache_controller_unit.sv
hdl/twcc_checker.sv
test/tb_top.sv
